// File: hw/rtl/bft_pkg.sv
// ----------------------------------------------------------------------------
// bft_pkg: shared types and constants of the tape unit
// Sizes of the tape, operation and result records, codes and helper functions.
// ----------------------------------------------------------------------------
package bft_pkg;

  localparam int unsigned TAPE_DEPTH = 4096;
  localparam int unsigned PTR_W      = $clog2(TAPE_DEPTH);
  localparam int unsigned CNT_W      = PTR_W + 1;
  localparam int unsigned ADDR_W     = PTR_W + 1;
  localparam int unsigned RAM_DEPTH  = 2 ** ADDR_W;

  localparam int unsigned CELLS_W    = 13;
  localparam int unsigned EOFM_W     = 2;
  localparam int unsigned MODE_W     = 4;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POINTER_W  = 12;
  localparam int unsigned WARN_W     = 2;
  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;

  // register index, taken from paddr[2]
  localparam logic REG_TAPE_CELLS = 1'b0;
  localparam logic REG_EOF_MODE   = 1'b1;
  localparam logic [CELLS_W-1:0] TAPE_CELLS_RST = CELLS_W'(4096);

  localparam logic [MODE_W-1:0] MODE_RIGHT  = 4'd0;
  localparam logic [MODE_W-1:0] MODE_LEFT   = 4'd1;
  localparam logic [MODE_W-1:0] MODE_INC    = 4'd2;
  localparam logic [MODE_W-1:0] MODE_DEC    = 4'd3;
  localparam logic [MODE_W-1:0] MODE_LSTART = 4'd4;
  localparam logic [MODE_W-1:0] MODE_LEND   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_READ   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_WRITE  = 4'd7;
  localparam logic [MODE_W-1:0] MODE_SWAP   = 4'd8;

  localparam logic [EOFM_W-1:0] EOF_KEEP = 2'd0;
  localparam logic [EOFM_W-1:0] EOF_ZERO = 2'd1;
  localparam logic [EOFM_W-1:0] EOF_DEC  = 2'd2;

  localparam logic [WARN_W-1:0] WARN_NONE  = 2'd0;
  localparam logic [WARN_W-1:0] WARN_WRAP  = 2'd1;
  localparam logic [WARN_W-1:0] WARN_CLAMP = 2'd2;

  typedef enum logic [3:0] {
    OP_RIGHT,
    OP_LEFT,
    OP_INC,
    OP_DEC,
    OP_LSTART,
    OP_LEND,
    OP_READ,
    OP_WRITE,
    OP_SWAP,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] in_byte;
    logic              in_eof;
  } op_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    cell_value;
    logic [POINTER_W-1:0] pointer;
    logic                 branch_taken;
    logic                 out_valid;
    logic [BYTE_W-1:0]    out_byte;
    logic [WARN_W-1:0]    pointer_warning;
    logic [POINTER_W-1:0] high_water;
  } res_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_FETCH,
    BK_LOAD,
    BK_RUN
  } back_state_e;

  // effective cell count: 0 acts as 1, anything above the tape acts as the tape
  function automatic logic [CNT_W-1:0] cells_in_use(input logic [CELLS_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) begin
      w = 32'd1;
    end else if (w > TAPE_DEPTH) begin
      w = 32'(TAPE_DEPTH);
    end
    return w[CNT_W-1:0];
  endfunction

  function automatic logic [POINTER_W-1:0] ptr_field(input logic [PTR_W-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return w[POINTER_W-1:0];
  endfunction

endpackage

// File: hw/rtl/bft_ram.sv
// ----------------------------------------------------------------------------
// bft_ram: generic single-port RAM
// One access per cycle, write or read; read data is registered.
// ----------------------------------------------------------------------------
module bft_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/bft_front.sv
// ----------------------------------------------------------------------------
// bft_front: operation intake
// Accepts operations, decodes the mode code and queues them for the back end.
// ----------------------------------------------------------------------------
module bft_front
  import bft_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              hold_i,
  input  logic              push_i,
  output logic              full_o,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [BYTE_W-1:0] in_byte_i,
  input  logic              in_eof_i,
  output logic              empty_o,
  input  logic              pop_i,
  output op_t               op_o
);

  op_t        slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  op_t        dec;
  logic       do_push, do_pop;

  always_comb begin
    dec.in_byte = in_byte_i;
    dec.in_eof  = in_eof_i;
    unique case (mode_i)
      MODE_RIGHT:  dec.op = OP_RIGHT;
      MODE_LEFT:   dec.op = OP_LEFT;
      MODE_INC:    dec.op = OP_INC;
      MODE_DEC:    dec.op = OP_DEC;
      MODE_LSTART: dec.op = OP_LSTART;
      MODE_LEND:   dec.op = OP_LEND;
      MODE_READ:   dec.op = OP_READ;
      MODE_WRITE:  dec.op = OP_WRITE;
      MODE_SWAP:   dec.op = OP_SWAP;
      default:     dec.op = OP_NOP;
    endcase
  end

  assign full_o  = (cnt_q == 2'd2) | hold_i;
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign op_o    = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ do_push;
    rd_d  = rd_q ^ do_pop;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= dec;
    end
  end

endmodule

// File: hw/rtl/bft_res_queue.sv
// ----------------------------------------------------------------------------
// bft_res_queue: result queue
// Two-entry queue of finished results toward the pop side.
// ----------------------------------------------------------------------------
module bft_res_queue
  import bft_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic full_o,
  output logic empty_o,
  input  logic pop_i,
  output res_t res_o
);

  res_t       slot_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign res_o   = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ do_push;
    rd_d  = rd_q ^ do_pop;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= res_i;
    end
  end

endmodule

// File: hw/rtl/bft_back.sv
// ----------------------------------------------------------------------------
// bft_back: tape execution
// Holds pointer, bank and current cell; updates the tape RAM and builds results.
// ----------------------------------------------------------------------------
module bft_back
  import bft_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CELLS_W-1:0] tape_cells_i,
  input  logic [EOFM_W-1:0]  eof_mode_i,
  input  logic               op_empty_i,
  input  op_t                op_i,
  output logic               op_pop_o,
  input  logic               res_full_i,
  output logic               res_push_o,
  output res_t               res_o,
  output logic               clearing_o
);

  back_state_e       state_q, state_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [PTR_W-1:0]  peak_q, peak_d;
  logic              bank_q, bank_d;
  logic              rcv_q, rcv_d;
  logic [BYTE_W-1:0] cell_q, cell_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic              pend_vld_q, pend_vld_d;
  res_t              pend_q, pend_d;

  logic              ram_en, ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  logic              run_go, run_move;
  logic [CNT_W-1:0]  cells, ptr_inc;
  logic [BYTE_W-1:0] rd_val;
  logic              rcv_next;
  res_t              res;

  bft_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RAM_DEPTH)
  ) u_tape (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign cells    = cells_in_use(tape_cells_i);
  assign ptr_inc  = {1'b0, ptr_q} + CNT_W'(1);
  assign run_go   = (state_q == BK_RUN) & ~op_empty_i & ~res_full_i;
  assign run_move = run_go & (op_i.op inside {OP_RIGHT, OP_LEFT, OP_SWAP});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_CLEAR: if (&clr_q) state_d = BK_FETCH;
      BK_FETCH: state_d = BK_LOAD;
      BK_LOAD:  state_d = BK_RUN;
      BK_RUN:   if (run_move) state_d = BK_FETCH;
      default:  state_d = BK_CLEAR;
    endcase
  end

  always_comb begin
    ptr_d      = ptr_q;
    peak_d     = peak_q;
    bank_d     = bank_q;
    rcv_d      = rcv_q;
    cell_d     = cell_q;
    clr_d      = clr_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = {bank_q, ptr_q};
    ram_wdata  = cell_q;
    op_pop_o   = 1'b0;
    res_push_o = 1'b0;
    clearing_o = 1'b0;
    rcv_next   = rcv_q;
    rd_val     = cell_q;

    res.cell_value      = cell_q;
    res.pointer         = ptr_field(ptr_q);
    res.branch_taken    = 1'b0;
    res.out_valid       = 1'b0;
    res.out_byte        = '0;
    res.pointer_warning = WARN_NONE;
    res.high_water      = ptr_field(peak_q);

    unique case (state_q)
      BK_CLEAR: begin
        clearing_o = 1'b1;
        ram_en     = 1'b1;
        ram_we     = 1'b1;
        ram_addr   = clr_q;
        ram_wdata  = '0;
        clr_d      = clr_q + ADDR_W'(1);
      end
      BK_FETCH: begin
        ram_en = 1'b1;
      end
      BK_LOAD: begin
        cell_d = ram_rdata;
        if (pend_vld_q) begin
          res            = pend_q;
          res.cell_value = ram_rdata;
          res_push_o     = 1'b1;
          pend_vld_d     = 1'b0;
        end
      end
      BK_RUN: begin
        if (run_go) begin
          op_pop_o   = 1'b1;
          res_push_o = ~run_move;
          case (op_i.op)
            OP_RIGHT: begin
              if (ptr_inc >= cells) begin
                ptr_d               = '0;
                res.pointer_warning = WARN_WRAP;
              end else begin
                ptr_d = ptr_inc[PTR_W-1:0];
                if (ptr_inc[PTR_W-1:0] > peak_q) begin
                  peak_d = ptr_inc[PTR_W-1:0];
                end
              end
            end
            OP_LEFT: begin
              if (ptr_q == '0) begin
                res.pointer_warning = WARN_CLAMP;
              end else begin
                ptr_d = ptr_q - PTR_W'(1);
              end
            end
            OP_SWAP: bank_d = ~bank_q;
            OP_INC: begin
              cell_d = cell_q + BYTE_W'(1);
              ram_en = 1'b1;
              ram_we = 1'b1;
            end
            OP_DEC: begin
              cell_d = cell_q - BYTE_W'(1);
              ram_en = 1'b1;
              ram_we = 1'b1;
            end
            OP_LSTART: res.branch_taken = (cell_q == '0);
            OP_LEND:   res.branch_taken = (cell_q != '0);
            OP_READ: begin
              // first read that sees end of input already takes the eof action
              rcv_next = rcv_q & ~op_i.in_eof;
              if (rcv_next) begin
                rd_val = op_i.in_byte;
              end else begin
                case (eof_mode_i)
                  EOF_ZERO: rd_val = '0;
                  EOF_DEC:  rd_val = cell_q - BYTE_W'(1);
                  default:  rd_val = cell_q;
                endcase
              end
              rcv_d  = rcv_next;
              cell_d = rd_val;
              ram_en = 1'b1;
              ram_we = 1'b1;
            end
            OP_WRITE: begin
              res.out_valid = 1'b1;
              res.out_byte  = cell_q;
            end
            default: ;
          endcase
          ram_wdata      = cell_d;
          res.cell_value = cell_d;
          res.pointer    = ptr_field(ptr_d);
          res.high_water = ptr_field(peak_d);
          if (run_move) begin
            pend_d     = res;
            pend_vld_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res_o = res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_CLEAR;
      ptr_q      <= '0;
      peak_q     <= '0;
      bank_q     <= 1'b0;
      rcv_q      <= 1'b1;
      clr_q      <= '0;
      pend_vld_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      peak_q     <= peak_d;
      bank_q     <= bank_d;
      rcv_q      <= rcv_d;
      clr_q      <= clr_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
    pend_q <= pend_d;
  end

endmodule

// File: hw/rtl/bf_tape_unit.sv
// ----------------------------------------------------------------------------
// bf_tape_unit: tape datapath of a byte-cell tape machine
// Front end queues decoded operations; back end runs them on a two-bank tape.
//
//   channel   handshake                     payload
//   --------  ----------------------------  ------------------------------------
//   ops in    push / full                   mode_i, in_byte_i, in_eof_i
//   results   empty / pop                   cell_value_o .. high_water_o
//   config    psel/penable/pwrite/pready    paddr, pwdata, prdata
//
// Cell, branch, read and write operations complete in the back end's run state.
// Moves and bank swaps go through update, tape RAM read and capture of the new cell
// (single-port tape RAM with registered read).
// After reset the tape RAM is cleared, one entry a cycle; full stays high
// meanwhile. Two-entry queues on both sides absorb stalls.
// ----------------------------------------------------------------------------
module bf_tape_unit
  import bft_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [MODE_W-1:0]    mode_i,
  input  logic [BYTE_W-1:0]    in_byte_i,
  input  logic                 in_eof_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [BYTE_W-1:0]    cell_value_o,
  output logic [POINTER_W-1:0] pointer_o,
  output logic                 branch_taken_o,
  output logic                 out_valid_o,
  output logic [BYTE_W-1:0]    out_byte_o,
  output logic [WARN_W-1:0]    pointer_warning_o,
  output logic [POINTER_W-1:0] high_water_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  logic [CELLS_W-1:0] tape_cells_q, tape_cells_d;
  logic [EOFM_W-1:0]  eof_mode_q, eof_mode_d;
  logic               cfg_wr;

  logic op_empty, op_pop, res_full, res_push, clearing;
  op_t  op;
  res_t res_in, res_out;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    tape_cells_d = tape_cells_q;
    eof_mode_d   = eof_mode_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_TAPE_CELLS: tape_cells_d = pwdata[CELLS_W-1:0];
        REG_EOF_MODE:   eof_mode_d   = pwdata[EOFM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TAPE_CELLS: prdata = PDATA_W'(tape_cells_q);
      REG_EOF_MODE:   prdata = PDATA_W'(eof_mode_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tape_cells_q <= TAPE_CELLS_RST;
      eof_mode_q   <= EOF_KEEP;
    end else begin
      tape_cells_q <= tape_cells_d;
      eof_mode_q   <= eof_mode_d;
    end
  end

  bft_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .hold_i    (clearing),
    .push_i    (push),
    .full_o    (full),
    .mode_i    (mode_i),
    .in_byte_i (in_byte_i),
    .in_eof_i  (in_eof_i),
    .empty_o   (op_empty),
    .pop_i     (op_pop),
    .op_o      (op)
  );

  bft_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tape_cells_i (tape_cells_q),
    .eof_mode_i   (eof_mode_q),
    .op_empty_i   (op_empty),
    .op_i         (op),
    .op_pop_o     (op_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_in),
    .clearing_o   (clearing)
  );

  bft_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_in),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (res_out)
  );

  assign cell_value_o      = res_out.cell_value;
  assign pointer_o         = res_out.pointer;
  assign branch_taken_o    = res_out.branch_taken;
  assign out_valid_o       = res_out.out_valid;
  assign out_byte_o        = res_out.out_byte;
  assign pointer_warning_o = res_out.pointer_warning;
  assign high_water_o      = res_out.high_water;

endmodule
